FILE: rtl/core/hfla_pkg.sv
// Shared constants and types for the handle free-list allocator.
package hfla_pkg;

	localparam int MAX_HANDLES = 1024;
	localparam int HANDLE_W    = $clog2(MAX_HANDLES);
	localparam int CNT_W       = $clog2(MAX_HANDLES + 1);
	localparam int ENTRY_W     = CNT_W + 1;

	localparam logic [CNT_W-1:0] EMPTY_MARK = CNT_W'(MAX_HANDLES);

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 24;

	localparam logic COMMAND_ALLOC   = 1'b0;
	localparam logic COMMAND_RELEASE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_RANGE = 2'd2;
	localparam logic [1:0] STATUS_FREE  = 2'd3;

	typedef logic [HANDLE_W-1:0] handle_t;
	typedef logic [CNT_W-1:0]    count_t;

	// one pool entry: allocated flag above the free-list link
	typedef struct packed {
		logic   allocated;
		count_t link;
	} entry_t;

endpackage

FILE: rtl/core/hfla_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/handle_free_list_allocator.sv
// Top level of the LIFO free-list handle allocator.
//
//  channel  dir  signals                      contents (low bit up)
//  s_*      in   s_tvalid s_tready s_tdata    tdata: handle_in[9:0]; tuser: command
//  m_*      out  m_tvalid m_tready m_tdata    tdata: handle_out[9:0], in_use[20:10];
//                                             tuser: status
//  cfg_*    in   cfg_valid cfg_ready cfg_data capacity[10:0]
//
//  The accept cycle reads the pool entry RAM; the S_EXEC state then resolves the
//  request and writes the entry back.
//  A new request is taken while a result waits in the output register; its
//  resolve cycle holds until that register drains.
//  Entries at or above the ascending-issue pointer read as free, so reset and capacity
//  writes take effect at once with no clearing pass.
module handle_free_list_allocator
	import hfla_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // handle_in[9:0], zero pad
	input  logic                   s_tuser,   // command
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // handle_out[9:0], in_use[20:10], zero pad
	output logic [1:0]             m_tuser,   // status
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CNT_W-1:0]       cfg_data
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic    state_q;
	logic    cmd_q;
	handle_t hin_q;
	count_t  top_q;
	count_t  fresh_q;
	count_t  used_q;
	count_t  cap_q;

	logic    out_valid_q;
	handle_t out_handle_q;
	logic [1:0] out_status_q;
	count_t  out_used_q;

	logic    in_accept;
	logic    exec_go;
	entry_t  rd_entry;
	logic [ENTRY_W-1:0] rd_data;

	logic    ram_we;
	handle_t ram_waddr;
	entry_t  ram_wentry;
	handle_t ram_raddr;

	handle_t    nxt_handle;
	logic [1:0] nxt_status;
	count_t     nxt_top;
	count_t     nxt_fresh;
	count_t     nxt_used;
	count_t     cap_clamped;

	assign s_tready  = (state_q == S_IDLE);
	assign in_accept = s_tvalid & s_tready;
	assign exec_go   = (state_q == S_EXEC) && (!out_valid_q || m_tready);
	assign cfg_ready = 1'b1;

	assign ram_raddr = (s_tuser == COMMAND_RELEASE) ? s_tdata[HANDLE_W-1:0]
		: top_q[HANDLE_W-1:0];
	assign rd_entry  = entry_t'(rd_data);

	hfla_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_HANDLES)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ENTRY_W'(ram_wentry)),
		.re    (in_accept),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	always_comb begin
		if (cfg_data == '0) begin
			cap_clamped = count_t'(1);
		end else if (cfg_data > EMPTY_MARK) begin
			cap_clamped = EMPTY_MARK;
		end else begin
			cap_clamped = cfg_data;
		end
	end

	always_comb begin
		nxt_handle = '0;
		nxt_status = STATUS_OK;
		nxt_top    = top_q;
		nxt_fresh  = fresh_q;
		nxt_used   = used_q;
		ram_we     = 1'b0;
		ram_waddr  = hin_q;
		ram_wentry = '{allocated: 1'b0, link: top_q};
		if (cmd_q == COMMAND_ALLOC) begin
			priority if (used_q >= cap_q) begin
				nxt_status = STATUS_FULL;
			end else if (top_q != EMPTY_MARK) begin
				nxt_handle = top_q[HANDLE_W-1:0];
				nxt_top    = rd_entry.link;
				nxt_used   = used_q + count_t'(1);
				ram_we     = 1'b1;
				ram_waddr  = top_q[HANDLE_W-1:0];
				ram_wentry = '{allocated: 1'b1, link: rd_entry.link};
			end else if (fresh_q < cap_q) begin
				nxt_handle = fresh_q[HANDLE_W-1:0];
				nxt_fresh  = fresh_q + count_t'(1);
				nxt_used   = used_q + count_t'(1);
				ram_we     = 1'b1;
				ram_waddr  = fresh_q[HANDLE_W-1:0];
				ram_wentry = '{allocated: 1'b1, link: EMPTY_MARK};
			end else begin
				nxt_status = STATUS_FULL;
			end
		end else begin
			priority if (count_t'(hin_q) >= cap_q) begin
				nxt_status = STATUS_RANGE;
			end else if (!(count_t'(hin_q) < fresh_q && rd_entry.allocated)) begin
				nxt_status = STATUS_FREE;
			end else begin
				nxt_top    = count_t'(hin_q);
				nxt_used   = used_q - count_t'(1);
				ram_we     = 1'b1;
				ram_waddr  = hin_q;
				ram_wentry = '{allocated: 1'b0, link: top_q};
			end
		end
		ram_we = ram_we & exec_go;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			top_q       <= EMPTY_MARK;
			fresh_q     <= '0;
			used_q      <= '0;
			cap_q       <= EMPTY_MARK;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_valid) begin
				cap_q   <= cap_clamped;
				top_q   <= EMPTY_MARK;
				fresh_q <= '0;
				used_q  <= '0;
			end else if (exec_go) begin
				top_q   <= nxt_top;
				fresh_q <= nxt_fresh;
				used_q  <= nxt_used;
			end

			if (exec_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= s_tuser;
			hin_q <= s_tdata[HANDLE_W-1:0];
		end
		if (exec_go) begin
			out_handle_q <= nxt_handle;
			out_status_q <= nxt_status;
			out_used_q   <= nxt_used;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {(OUT_TDATA_W - CNT_W - HANDLE_W)'(0), out_used_q, out_handle_q};

endmodule

FILE: rtl/core/hfla_checker.sv
// Port-level checks for the handle free-list allocator, bound to the top level.
module hfla_checker
	import hfla_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic [1:0]             m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STATUS_OK |-> m_tdata[HANDLE_W-1:0] == '0)
		else $error("nonzero handle on failed transaction");

	a_full_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_FULL |-> m_tdata[CNT_W+HANDLE_W-1:HANDLE_W] != '0)
		else $error("pool full reported with no handle in use");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CNT_W+HANDLE_W-1:HANDLE_W] <= EMPTY_MARK)
		else $error("in-use count above pool size");

endmodule

bind handle_free_list_allocator hfla_checker u_hfla_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
